### rtl/core/bitmap_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap frame allocator
// Shared property wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Codes, field widths and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int CMD_W        = 2;
	localparam int ADDR_W       = 30;
	localparam int STATUS_W     = 2;
	localparam int USED_W       = 19;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 19;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 56;
	localparam int WORD_W       = 64;
	localparam int BIT_W        = 6;
	localparam int FRAME_SHIFT  = 12;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [WORD_W-1:0]   word_t;

	localparam cmd_t CMD_INIT  = 2'd0;
	localparam cmd_t CMD_ALLOC = 2'd1;
	localparam cmd_t CMD_FREE  = 2'd2;
	localparam cmd_t CMD_NOP   = 2'd3;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_OOM      = 2'd1;
	localparam status_t STAT_BEYOND   = 2'd2;
	localparam status_t STAT_NOT_USED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 2'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_COUNT_RST = 19'd262144;
	localparam logic [CFG_DATA_W-1:0] RESERVED_RST    = 19'd1024;

endpackage

### rtl/core/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page frame allocator keeping one used bit per 4 KB frame in a RAM.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel (tuser: command, tdata: free
// address); one result per command leaves on m_axis (tuser: status, tdata:
// block address and used frame count). The cfg channel writes frame_count
// (index 0) and reserved_frames (index 1) and is always ready.
// The bitmap sits in a RAM of 64-bit words read one word per cycle, so with
// W = ceil(MAX_FRAMES/64) words (4096 by default):
//   init  : every word written in turn, then the result
//   alloc : words scanned up to the first free bit (at most W), then write-back
//   free  : word read, bit cleared; no-op and rejected commands go to result
// One command is in flight at a time; s_axis_tready is high only while the
// block is idle. A finished result waits in the output register while the
// next command is taken; a held result stalls completion of the next one.
// After reset the RAM is filled with ones, one word per cycle, over all W words
// with s_axis_tready low; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = 262144
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [29:0] free_address, [31:30] zero
	input  logic [bfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] command
	input  logic [bfa_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [29:0] block_address, [48:30] used_frames, [55:49] zero
	output logic [bfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// [1:0] status
	output logic [bfa_pkg::STATUS_W-1:0]      m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int WORDS  = (MAX_FRAMES + 63) / 64;
	localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BASE_W = WA_W + bfa_pkg::BIT_W;
	localparam int MF_W   = $clog2(MAX_FRAMES + 1);
	localparam int CNT_W  = (MF_W > bfa_pkg::USED_W) ? MF_W : bfa_pkg::USED_W;
	localparam int CMP_W  = (CNT_W > BASE_W) ? CNT_W : BASE_W;
	localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_FRAMES);
	localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORDS - 1);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_AWR   = 3'd4;
	localparam logic [2:0] ST_FREE  = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	function automatic bfa_pkg::word_t bits_from(input logic [CMP_W-1:0] base,
			input logic [CMP_W-1:0] a);
		logic [CMP_W-1:0] d;
		d = a - base;
		if (a <= base) begin
			bits_from = '1;
		end else if (d >= CMP_W'(bfa_pkg::WORD_W)) begin
			bits_from = '0;
		end else begin
			bits_from = {bfa_pkg::WORD_W{1'b1}} << d[bfa_pkg::BIT_W-1:0];
		end
	endfunction

	function automatic logic [bfa_pkg::BIT_W-1:0] encode(input bfa_pkg::word_t oh);
		logic [bfa_pkg::BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < bfa_pkg::WORD_W; i++) begin
			if (oh[i]) begin
				idx = idx | bfa_pkg::BIT_W'(i);
			end
		end
		encode = idx;
	endfunction

	logic [2:0]                       state_q;
	logic [WA_W-1:0]                  addr_q;
	logic [bfa_pkg::BIT_W-1:0]        bit_q;
	bfa_pkg::word_t                   word_q;
	bfa_pkg::word_t                   freebits_q;
	logic [CNT_W-1:0]                 used_q;
	logic [bfa_pkg::CFG_DATA_W-1:0]   frame_count_q;
	logic [bfa_pkg::CFG_DATA_W-1:0]   reserved_q;
	bfa_pkg::status_t                 res_status_q;
	logic [bfa_pkg::ADDR_W-1:0]       res_block_q;
	logic                             out_valid_q;
	bfa_pkg::status_t                 out_status_q;
	logic [bfa_pkg::ADDR_W-1:0]       out_block_q;
	logic [bfa_pkg::USED_W-1:0]       out_used_q;

	logic                             ram_we;
	logic [WA_W-1:0]                  ram_waddr;
	bfa_pkg::word_t                   ram_wdata;
	logic [WA_W-1:0]                  ram_raddr;
	bfa_pkg::word_t                   ram_rdata;

	logic [CNT_W-1:0]                 lim;
	logic [CMP_W-1:0]                 lim_c;
	logic [CMP_W-1:0]                 res_c;
	logic [CMP_W-1:0]                 base;
	logic [CMP_W-1:0]                 frame_c;
	bfa_pkg::cmd_t                    cmd;
	bfa_pkg::word_t                   freed;
	bfa_pkg::word_t                   scan_free;
	bfa_pkg::word_t                   onehot;
	bfa_pkg::word_t                   free_mask;
	logic [bfa_pkg::BIT_W-1:0]        hit_bit;
	logic [BASE_W-1:0]                hit_frame;
	logic                             in_fire;
	logic                             out_free;

	assign cmd       = s_axis_tuser;
	assign lim       = (CNT_W'(frame_count_q) > MAX_C) ? MAX_C : CNT_W'(frame_count_q);
	assign lim_c     = CMP_W'(lim);
	assign res_c     = CMP_W'(reserved_q);
	assign base      = CMP_W'({addr_q, {bfa_pkg::BIT_W{1'b0}}});
	assign frame_c   = CMP_W'(s_axis_tdata[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT]);
	assign freed     = bits_from(base, res_c) & ~bits_from(base, lim_c);
	assign scan_free = ~ram_rdata & ~bits_from(base, lim_c);
	assign onehot    = freebits_q & (~freebits_q + 1'b1);
	assign hit_bit   = encode(onehot);
	assign hit_frame = {addr_q, hit_bit};
	assign free_mask = bfa_pkg::word_t'(1) << bit_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = bfa_pkg::OUT_TDATA_W'({out_used_q, out_block_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_wdata = '1;
			end
			ST_IDLE: begin
				ram_raddr = (cmd == bfa_pkg::CMD_FREE) ? frame_c[BASE_W-1:bfa_pkg::BIT_W] : '0;
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = ~freed;
			end
			ST_SCAN: begin
				ram_raddr = addr_q + 1'b1;
			end
			ST_AWR: begin
				ram_we    = 1'b1;
				ram_wdata = word_q | onehot;
			end
			ST_FREE: begin
				ram_we    = |(ram_rdata & free_mask);
				ram_wdata = ram_rdata & ~free_mask;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bfa_ram #(
		.WIDTH(bfa_pkg::WORD_W),
		.DEPTH(WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= bfa_pkg::FRAME_COUNT_RST;
			reserved_q    <= bfa_pkg::RESERVED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data;
				bfa_pkg::REG_RESERVED:    reserved_q    <= cfg_data;
				default:                  frame_count_q <= frame_count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_block_q  <= '0;
				res_status_q <= bfa_pkg::STAT_OK;
				bit_q        <= frame_c[bfa_pkg::BIT_W-1:0];
				if (cmd == bfa_pkg::CMD_ALLOC && used_q >= lim) begin
					res_status_q <= bfa_pkg::STAT_OOM;
				end
				if (cmd == bfa_pkg::CMD_FREE && frame_c >= lim_c) begin
					res_status_q <= bfa_pkg::STAT_BEYOND;
				end
			end
			ST_SCAN: begin
				freebits_q <= scan_free;
				word_q     <= ram_rdata;
				if (base >= lim_c || (scan_free == '0 && addr_q == LAST_WORD)) begin
					res_status_q <= bfa_pkg::STAT_OOM;
				end
			end
			ST_AWR: begin
				res_block_q <= bfa_pkg::ADDR_W'({hit_frame, {bfa_pkg::FRAME_SHIFT{1'b0}}});
			end
			ST_FREE: begin
				if ((ram_rdata & free_mask) == '0) begin
					res_status_q <= bfa_pkg::STAT_NOT_USED;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			addr_q       <= '0;
			used_q       <= MAX_C;
			out_valid_q  <= 1'b0;
			out_status_q <= bfa_pkg::STAT_OK;
			out_block_q  <= '0;
			out_used_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_WORD) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						addr_q <= '0;
						case (cmd)
							bfa_pkg::CMD_INIT: state_q <= ST_INIT;
							bfa_pkg::CMD_ALLOC: begin
								state_q <= (used_q >= lim) ? ST_RESP : ST_SCAN;
							end
							bfa_pkg::CMD_FREE: begin
								addr_q  <= frame_c[BASE_W-1:bfa_pkg::BIT_W];
								state_q <= (frame_c >= lim_c) ? ST_RESP : ST_FREE;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_INIT: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_WORD) begin
						used_q  <= (CNT_W'(reserved_q) < lim) ? CNT_W'(reserved_q) : lim;
						state_q <= ST_RESP;
					end
				end
				ST_SCAN: begin
					if (base >= lim_c) begin
						state_q <= ST_RESP;
					end else if (scan_free != '0) begin
						state_q <= ST_AWR;
					end else if (addr_q == LAST_WORD) begin
						state_q <= ST_RESP;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_AWR: begin
					used_q  <= used_q + 1'b1;
					state_q <= ST_RESP;
				end
				ST_FREE: begin
					if ((ram_rdata & free_mask) != '0 && used_q != '0) begin
						used_q <= used_q - 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_block_q  <= res_block_q;
						out_used_q   <= used_q[bfa_pkg::USED_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level assertions for the bitmap frame allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [bfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [bfa_pkg::STATUS_W-1:0]      m_axis_tuser
);

	`BFA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`BFA_ASSERT_SAME(a_addr_ok, clk, arst_n, m_axis_tvalid && m_axis_tdata[29:0] != 30'd0, m_axis_tuser == bfa_pkg::STAT_OK)
	`BFA_ASSERT_SAME(a_addr_align, clk, arst_n, m_axis_tvalid, m_axis_tdata[11:0] == 12'd0 && m_axis_tdata[55:49] == 7'd0)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

### verif/bitmap_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Self-checking bench for the bitmap frame allocator. A directed table covers
// reset state, address extremes, the error statuses, a trailing partial
// bitmap word and registers changed without init. Random phases then sweep
// frame and reserved counts and run mixed init, alloc, free and no-op
// traffic. A local bitmap model predicts each result that the table does not
// give. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_FRAMES    = 262144;
	localparam int unsigned MAP_WORDS     = MAX_FRAMES / 64;
	localparam int unsigned IDLE_LIMIT    = 50000;
	localparam int unsigned RANDOM_ITEMS  = 105;
	localparam int unsigned SETTLE_CYCLES = 4200;
	localparam int unsigned PLAN_ROWS     = 28;
	localparam logic [bfa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		bfa_pkg::status_t                  status;
		logic [bfa_pkg::ADDR_W-1:0]        block_address;
		logic [bfa_pkg::USED_W-1:0]        used_frames;
	} alloc_result_t;

	typedef enum logic [0:0] {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                         kind;
		bfa_pkg::cmd_t                     cmd;
		logic [bfa_pkg::ADDR_W-1:0]        addr;
		logic [bfa_pkg::CFG_DATA_W-1:0]    fc;
		logic [bfa_pkg::CFG_DATA_W-1:0]    rs;
		logic                              typed;
		alloc_result_t                     want;
	} plan_row_t;

	localparam alloc_result_t NO_WANT = '0;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [bfa_pkg::IN_TDATA_W-1:0]       s_axis_tdata = '0;
	logic [bfa_pkg::CMD_W-1:0]            s_axis_tuser = '0;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [bfa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata;
	logic [bfa_pkg::STATUS_W-1:0]         m_axis_tuser;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [bfa_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [bfa_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

	logic [63:0]                          frame_words [0:MAP_WORDS-1];
	logic [bfa_pkg::USED_W-1:0]           used_total;
	logic [bfa_pkg::CFG_DATA_W-1:0]       cur_frame_count;
	logic [bfa_pkg::CFG_DATA_W-1:0]       cur_reserved;

	alloc_result_t            awaited_replies [$];
	int unsigned              granted_frames [$];
	int unsigned              burst_left = 0;
	int unsigned              errors = 0;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OOM, 30'h0, 19'd262144}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h3FFFFFFF, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd262143}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h3FFFFFFF, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_NOT_USED, 30'h0, 19'd262143}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h3FFFF000, 19'd262144}},
		'{ROW_CMD, bfa_pkg::CMD_NOP, 30'h3FFFFFFF, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd262144}},
		'{ROW_CMD, bfa_pkg::CMD_INIT, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd1024}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h400000, 19'd1025}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h400FFF, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd1024}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd1023}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd1024}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h500000, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_NOT_USED, 30'h0, 19'd1024}},
		'{ROW_CFG, bfa_pkg::CMD_NOP, 30'h0, 19'd0, 19'd0, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OOM, 30'h0, 19'd1024}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_BEYOND, 30'h0, 19'd1024}},
		'{ROW_CMD, bfa_pkg::CMD_INIT, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd0}},
		'{ROW_CFG, bfa_pkg::CMD_NOP, 30'h0, 19'd70, 19'd66, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h2000, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd0}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h2000, 19'd1}},
		'{ROW_CMD, bfa_pkg::CMD_INIT, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd66}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OOM, 30'h0, 19'd70}},
		'{ROW_CFG, bfa_pkg::CMD_NOP, 30'h0, 19'd524287, 19'd524287, 1'b0, NO_WANT},
		'{ROW_CMD, bfa_pkg::CMD_INIT, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd262144}},
		'{ROW_CMD, bfa_pkg::CMD_FREE, 30'h1000, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h0, 19'd262143}},
		'{ROW_CMD, bfa_pkg::CMD_ALLOC, 30'h0, 19'd0, 19'd0, 1'b1,
			'{bfa_pkg::STAT_OK, 30'h1000, 19'd262144}}
	};

	bitmap_frame_allocator #(
		.MAX_FRAMES(MAX_FRAMES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned frame_limit_now();
		if (cur_frame_count > MAX_FRAMES) return MAX_FRAMES;
		return cur_frame_count;
	endfunction

	function automatic logic [63:0] mask_at_or_above(int unsigned base, int unsigned a);
		if (a <= base) return '1;
		if (a - base >= 64) return '0;
		return {64{1'b1}} << (a - base);
	endfunction

	function automatic alloc_result_t apply_command(bfa_pkg::cmd_t cmd,
			logic [bfa_pkg::ADDR_W-1:0] addr);
		int unsigned lim;
		int unsigned res;
		int unsigned base;
		int unsigned frame;
		logic [63:0] open_bits;
		logic found;
		alloc_result_t r;
		lim = frame_limit_now();
		r = '0;
		r.status = bfa_pkg::STAT_OK;
		found = 1'b0;
		case (cmd)
			bfa_pkg::CMD_INIT: begin
				res = cur_reserved;
				for (int w = 0; w < MAP_WORDS; w++) begin
					base = w * 64;
					frame_words[w] = ~(mask_at_or_above(base, res) & ~mask_at_or_above(base, lim));
				end
				used_total = bfa_pkg::USED_W'((res < lim) ? res : lim);
			end
			bfa_pkg::CMD_ALLOC: begin
				if (used_total < lim) begin
					for (int w = 0; w < MAP_WORDS && !found && w * 64 < lim; w++) begin
						base = w * 64;
						open_bits = ~frame_words[w] & ~mask_at_or_above(base, lim);
						if (open_bits != '0) begin
							for (int j = 0; j < 64 && !found; j++) begin
								if (open_bits[j]) begin
									frame_words[w][j] = 1'b1;
									used_total = used_total + 1'b1;
									r.block_address =
										bfa_pkg::ADDR_W'((base + j) << bfa_pkg::FRAME_SHIFT);
									found = 1'b1;
								end
							end
						end
					end
				end
				if (!found) r.status = bfa_pkg::STAT_OOM;
			end
			bfa_pkg::CMD_FREE: begin
				frame = 32'(addr >> bfa_pkg::FRAME_SHIFT);
				if (frame >= lim) begin
					r.status = bfa_pkg::STAT_BEYOND;
				end else if (!frame_words[frame / 64][frame % 64]) begin
					r.status = bfa_pkg::STAT_NOT_USED;
				end else begin
					frame_words[frame / 64][frame % 64] = 1'b0;
					if (used_total != 0) used_total = used_total - 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.used_frames = used_total;
		return r;
	endfunction

	task automatic push_command(input bfa_pkg::cmd_t cmd,
			input logic [bfa_pkg::ADDR_W-1:0] addr,
			input logic typed, input alloc_result_t want);
		alloc_result_t predicted;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, addr};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = apply_command(cmd, addr);
		if (cmd == bfa_pkg::CMD_ALLOC && predicted.status == bfa_pkg::STAT_OK) begin
			granted_frames.push_back(32'(predicted.block_address >> bfa_pkg::FRAME_SHIFT));
			if (granted_frames.size() > 128) void'(granted_frames.pop_front());
		end
		awaited_replies.push_back(typed ? want : predicted);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_replies.size() != 0) @(negedge clk);
	endtask

	task automatic write_regs(input logic [bfa_pkg::CFG_DATA_W-1:0] fc,
			input logic [bfa_pkg::CFG_DATA_W-1:0] rs,
			input logic [bfa_pkg::CFG_DATA_W-1:0] filler);
		logic [bfa_pkg::CFG_IDX_W-1:0] idx [3];
		logic [bfa_pkg::CFG_DATA_W-1:0] val [3];
		idx = '{bfa_pkg::REG_FRAME_COUNT, bfa_pkg::REG_RESERVED, REG_SPARE};
		val = '{fc, rs, filler};
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (idx[k] == bfa_pkg::REG_FRAME_COUNT) cur_frame_count = val[k];
			else if (idx[k] == bfa_pkg::REG_RESERVED) cur_reserved = val[k];
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : reply_check
		alloc_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected result, actual status %0d addr %h used %0d", $time,
					m_axis_tuser, m_axis_tdata[29:0], m_axis_tdata[48:30]);
				errors++;
			end else begin
				want = awaited_replies.pop_front();
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[29:0] !== want.block_address) begin
					$display("%0t: block_address expected %h actual %h", $time,
						want.block_address, m_axis_tdata[29:0]);
					errors++;
				end
				if (m_axis_tdata[48:30] !== want.used_frames) begin
					$display("%0t: used_frames expected %0d actual %0d", $time,
						want.used_frames, m_axis_tdata[48:30]);
					errors++;
				end
			end
		end
	end

	initial begin : sink_pacing
		int unsigned mode;
		int unsigned span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 48);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= 1'b0;
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_items;
		int unsigned fc;
		int unsigned rs;
		int unsigned lim;
		int unsigned pick;
		int unsigned frame;
		int unsigned n_cmds;
		bfa_pkg::cmd_t cmd;
		logic [bfa_pkg::ADDR_W-1:0] addr;

		for (int w = 0; w < MAP_WORDS; w++) frame_words[w] = '1;
		used_total = bfa_pkg::USED_W'(MAX_FRAMES);
		cur_frame_count = bfa_pkg::FRAME_COUNT_RST;
		cur_reserved = bfa_pkg::RESERVED_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < PLAN_ROWS; k++) begin
			if (plan[k].kind == ROW_CFG) begin
				drain_replies();
				write_regs(plan[k].fc, plan[k].rs, 19'($urandom));
			end else begin
				push_command(plan[k].cmd, plan[k].addr, plan[k].typed, plan[k].want);
			end
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain_replies();
			case ($urandom_range(0, 5))
				0: begin
					fc = $urandom_range(1, 200);
					rs = $urandom_range(0, fc + 8);
				end
				1: begin
					fc = $urandom_range(8, 260);
					rs = fc - $urandom_range(0, 6);
				end
				2: begin
					fc = MAX_FRAMES;
					rs = $urandom_range(0, 1) ? $urandom_range(0, 2048)
						: MAX_FRAMES - $urandom_range(0, 4);
				end
				3: begin
					fc = $urandom_range(MAX_FRAMES + 1, 524287);
					rs = $urandom_range(0, 524287);
				end
				4: begin
					fc = 0;
					rs = $urandom_range(0, 524287);
				end
				default: begin
					fc = $urandom_range(64, 4095);
					rs = $urandom_range(0, fc);
				end
			endcase
			write_regs(bfa_pkg::CFG_DATA_W'(fc), bfa_pkg::CFG_DATA_W'(rs), 19'($urandom));
			lim = frame_limit_now();
			if ($urandom_range(0, 9) < 8) begin
				push_command(bfa_pkg::CMD_INIT, 30'($urandom), 1'b0, NO_WANT);
				random_items++;
			end
			n_cmds = $urandom_range(8, 24);
			repeat (n_cmds) begin
				pick = $urandom_range(0, 99);
				addr = 30'($urandom);
				if (pick < 45) begin
					cmd = bfa_pkg::CMD_ALLOC;
				end else if (pick < 90) begin
					cmd = bfa_pkg::CMD_FREE;
					pick = $urandom_range(0, 99);
					if (pick < 55 && granted_frames.size() != 0) begin
						frame = granted_frames[$urandom_range(0, granted_frames.size() - 1)];
						addr = bfa_pkg::ADDR_W'((frame << bfa_pkg::FRAME_SHIFT) |
							$urandom_range(0, 4095));
					end else if (pick < 80) begin
						frame = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
						addr = bfa_pkg::ADDR_W'((frame << bfa_pkg::FRAME_SHIFT) |
							$urandom_range(0, 4095));
					end else if (pick < 90) begin
						frame = lim - ((lim > 0) ? $urandom_range(0, 1) : 0);
						if (frame > MAX_FRAMES - 1) frame = MAX_FRAMES - 1;
						addr = bfa_pkg::ADDR_W'((frame << bfa_pkg::FRAME_SHIFT) |
							$urandom_range(0, 4095));
					end
				end else if (pick < 95) begin
					cmd = bfa_pkg::CMD_INIT;
				end else begin
					cmd = bfa_pkg::CMD_NOP;
				end
				push_command(cmd, addr, 1'b0, NO_WANT);
				random_items++;
			end
		end

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
